// ----- src/assert_macros.svh -----
// Assertion macros used by the update master core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked check, held off while reset is asserted.
`define SDSUM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");
// Clocked check that also holds during reset.
`define SDSUM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define SDSUM_ASSERT(lbl, clk, rstn, prop)
`define SDSUM_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/sdsum_pkg.sv -----
// Package: types, codes and reset values of the segment display serial master.
`default_nettype none
package sdsum_pkg;

  localparam int DEF_MAX_DIGITS = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_DELAY  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_CMD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ADDR_BASE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DISP_BASE  = 3'd5;

  localparam logic [15:0] RST_BIT_DELAY  = 16'd1;
  localparam logic [2:0]  RST_BRIGHTNESS = 3'd7;
  localparam logic        RST_DISP_EN    = 1'b1;
  localparam logic [7:0]  RST_DATA_CMD   = 8'h40;
  localparam logic [7:0]  RST_ADDR_BASE  = 8'hC0;
  localparam logic [7:0]  RST_DISP_BASE  = 8'h80;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_START = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START,
    PH_BCLKLO,
    PH_BDATA,
    PH_BCLKHI,
    PH_ACLKLO,
    PH_ACLKHI,
    PH_ASAMPLE,
    PH_ACLKLO2,
    PH_PDATLO,
    PH_PCLKHI,
    PH_PDATREL,
    PH_FINISH
  } phase_t;

endpackage
`default_nettype wire

// ----- src/segment_display_serial_update_master_core.sv -----
// Top level: two-wire LSB-first segment display update master with ack sampling.
//
// Usage:
//   in_*   : one beat per tick, digit load or start request (action in in_tuser).
//   out_*  : exactly one result beat per input beat, in order. out_tdata carries
//            the open-drain pull-downs, busy and the last ack level; out_tlast
//            marks the tick on which the final stop wait expires.
//   cfg_*  : register writes (index, data), always ready; write only when idle.
// A result is registered and appears in the cycle after its input beat is taken.
// Throughput: one beat per cycle unless a held result stalls the input; the phase
//   machine, counters and command formation are combinational between the input and the result register.
// A bus step happens on a tick beat once the delay counter has run down.
// Reset: bus released, sequencer idle, ack level 1, registers at defaults.
//   The digit buffer is not cleared; load every slot that an update will send.
// Stall: a held result keeps its value; in_tready drops only while the result
//   register is full and out_tready is low.
`default_nettype none
`include "assert_macros.svh"
module segment_display_serial_update_master_core
  import sdsum_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output      logic                  in_tready,
  // [7:0] digit_value, [10:8] digit_slot, [13:11] update_length,
  // [15:14] update_position, [16] dio_sense, [23:17] zero
  input  wire logic [23:0]           in_tdata,
  // [1:0] action
  input  wire logic [1:0]            in_tuser,
  output      logic                  out_tvalid,
  input  wire logic                  out_tready,
  // [0] clock_pull_low, [1] data_pull_low, [2] busy_res, [3] last_ack_level,
  // [7:4] zero
  output      logic [7:0]            out_tdata,
  // update_done
  output      logic                  out_tlast,
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [3:0] MAX_CNT = 4'(MAX_DIGITS);

  // configuration
  logic [15:0] bit_delay_r;
  logic [2:0]  bright_r;
  logic        disp_en_r;
  logic [7:0]  data_cmd_r;
  logic [7:0]  addr_base_r;
  logic [7:0]  disp_base_r;

  // sequencer state
  phase_t      phase_r, phase_nxt;
  logic [1:0]  frame_r, frame_nxt;
  logic [2:0]  byte_cnt_r, byte_cnt_nxt;
  logic [3:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic        clk_low_r, clk_low_nxt;
  logic        dat_low_r, dat_low_nxt;
  logic        ack_r, ack_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [7:0]  digit_buf_r [MAX_DIGITS];

  // result register
  logic        out_valid_r;
  logic [3:0]  out_bits_r;
  logic        out_done_r;
  logic        done_nxt;

  // input fields
  action_t     act;
  logic [7:0]  in_digit;
  logic [2:0]  in_slot;
  logic [2:0]  in_len;
  logic [1:0]  in_pos;
  logic        in_sense;

  logic        in_acc;
  logic        busy;
  logic        tick;
  logic        step;
  logic        finish;
  logic [3:0]  bit_inc;
  logic        more_digits;
  logic [7:0]  digit_rd;
  logic [7:0]  next_cmd;

  assign act      = action_t'(in_tuser);
  assign in_digit = in_tdata[7:0];
  assign in_slot  = in_tdata[10:8];
  assign in_len   = in_tdata[13:11];
  assign in_pos   = in_tdata[15:14];
  assign in_sense = in_tdata[16];

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign busy    = (phase_r != PH_IDLE);
  assign tick    = in_acc && (act == ACT_TICK) && busy && (delay_r == 16'd0);
  assign finish  = tick && (phase_r == PH_FINISH);
  assign step    = tick && (phase_r != PH_FINISH);
  assign bit_inc = bit_cnt_r + 4'd1;
  assign more_digits = (frame_r == 2'd1) && (byte_cnt_r < len_r) &&
                       ({1'b0, byte_cnt_r} < MAX_CNT);
  assign digit_rd = digit_buf_r[byte_cnt_r[IDX_W-1:0]];

  // command for the frame that follows the current one
  always_comb begin
    if (frame_r == 2'd0) begin
      next_cmd = addr_base_r + {6'd0, pos_r};
    end else begin
      next_cmd = disp_base_r + {4'd0, disp_en_r, bright_r};
    end
  end

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_acc && (act == ACT_START) && !busy) begin
      phase_nxt = PH_START;
    end else if (finish) begin
      phase_nxt = PH_IDLE;
    end else if (step) begin
      case (phase_r)
        PH_START:   phase_nxt = PH_BCLKLO;
        PH_BCLKLO:  phase_nxt = PH_BDATA;
        PH_BDATA:   phase_nxt = PH_BCLKHI;
        PH_BCLKHI:  phase_nxt = (bit_inc >= BITS_PER_BYTE) ? PH_ACLKLO : PH_BCLKLO;
        PH_ACLKLO:  phase_nxt = PH_ACLKHI;
        PH_ACLKHI:  phase_nxt = PH_ASAMPLE;
        PH_ASAMPLE: phase_nxt = PH_ACLKLO2;
        PH_ACLKLO2: phase_nxt = more_digits ? PH_BCLKLO : PH_PDATLO;
        PH_PDATLO:  phase_nxt = PH_PCLKHI;
        PH_PCLKHI:  phase_nxt = PH_PDATREL;
        PH_PDATREL: phase_nxt = (frame_r < 2'd2) ? PH_START : PH_FINISH;
        default:    phase_nxt = PH_IDLE;
      endcase
    end
  end

  // datapath and pin drive
  always_comb begin
    frame_nxt    = frame_r;
    byte_cnt_nxt = byte_cnt_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    delay_nxt    = delay_r;
    clk_low_nxt  = clk_low_r;
    dat_low_nxt  = dat_low_r;
    ack_nxt      = ack_r;
    len_nxt      = len_r;
    pos_nxt      = pos_r;
    done_nxt     = 1'b0;
    if (in_acc && (act == ACT_START) && !busy) begin
      len_nxt      = ({1'b0, in_len} > MAX_CNT) ? MAX_CNT[2:0] : in_len;
      pos_nxt      = in_pos;
      frame_nxt    = 2'd0;
      byte_cnt_nxt = 3'd0;
      bit_cnt_nxt  = 4'd0;
      shift_nxt    = data_cmd_r;
      delay_nxt    = 16'd0;
    end else if (in_acc && (act == ACT_TICK) && busy && (delay_r != 16'd0)) begin
      delay_nxt = delay_r - 16'd1;
    end else if (finish) begin
      done_nxt = 1'b1;
    end else if (step) begin
      delay_nxt = bit_delay_r;
      case (phase_r)
        PH_START: begin
          dat_low_nxt = 1'b1;
          bit_cnt_nxt = 4'd0;
        end
        PH_BCLKLO: clk_low_nxt = 1'b1;
        PH_BDATA:  dat_low_nxt = !shift_r[0];
        PH_BCLKHI: begin
          clk_low_nxt = 1'b0;
          shift_nxt   = {1'b0, shift_r[7:1]};
          bit_cnt_nxt = bit_inc;
        end
        PH_ACLKLO: begin
          clk_low_nxt = 1'b1;
          dat_low_nxt = 1'b0;
        end
        PH_ACLKHI: clk_low_nxt = 1'b0;
        PH_ASAMPLE: begin
          ack_nxt = in_sense;
          if (!in_sense) begin
            dat_low_nxt = 1'b1;
          end
        end
        PH_ACLKLO2: begin
          clk_low_nxt = 1'b1;
          if (more_digits) begin
            shift_nxt    = digit_rd;
            byte_cnt_nxt = byte_cnt_r + 3'd1;
            bit_cnt_nxt  = 4'd0;
          end
        end
        PH_PDATLO: dat_low_nxt = 1'b1;
        PH_PCLKHI: clk_low_nxt = 1'b0;
        PH_PDATREL: begin
          dat_low_nxt = 1'b0;
          if (frame_r < 2'd2) begin
            frame_nxt = frame_r + 2'd1;
            shift_nxt = next_cmd;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_delay_r <= RST_BIT_DELAY;
      bright_r    <= RST_BRIGHTNESS;
      disp_en_r   <= RST_DISP_EN;
      data_cmd_r  <= RST_DATA_CMD;
      addr_base_r <= RST_ADDR_BASE;
      disp_base_r <= RST_DISP_BASE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BIT_DELAY:  bit_delay_r <= cfg_data;
        REG_BRIGHTNESS: bright_r    <= cfg_data[2:0];
        REG_DISP_EN:    disp_en_r   <= cfg_data[0];
        REG_DATA_CMD:   data_cmd_r  <= cfg_data[7:0];
        REG_ADDR_BASE:  addr_base_r <= cfg_data[7:0];
        REG_DISP_BASE:  disp_base_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      frame_r    <= 2'd0;
      byte_cnt_r <= 3'd0;
      bit_cnt_r  <= 4'd0;
      shift_r    <= 8'd0;
      delay_r    <= 16'd0;
      clk_low_r  <= 1'b0;
      dat_low_r  <= 1'b0;
      ack_r      <= 1'b1;
      len_r      <= 3'd0;
      pos_r      <= 2'd0;
    end else begin
      phase_r    <= phase_nxt;
      frame_r    <= frame_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      delay_r    <= delay_nxt;
      clk_low_r  <= clk_low_nxt;
      dat_low_r  <= dat_low_nxt;
      ack_r      <= ack_nxt;
      len_r      <= len_nxt;
      pos_r      <= pos_nxt;
    end
  end

  // digit buffer, no reset
  always_ff @(posedge clk) begin
    if (in_acc && (act == ACT_LOAD) && ({1'b0, in_slot} < MAX_CNT)) begin
      digit_buf_r[in_slot[IDX_W-1:0]] <= in_digit;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_bits_r <= {ack_nxt, (phase_nxt != PH_IDLE), dat_low_nxt, clk_low_nxt};
      out_done_r <= done_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_bits_r};
  assign out_tlast  = out_done_r;

  `SDSUM_ASSERT(a_stall_blocks_input, clk, rst_n, (out_valid_r && !out_tready) |-> !in_tready)
  `SDSUM_ASSERT(a_idle_no_delay, clk, rst_n, (phase_r == PH_IDLE) |-> (delay_r == 16'd0))
  `SDSUM_ASSERT(a_bit_cnt_range, clk, rst_n, bit_cnt_r <= BITS_PER_BYTE)
  `SDSUM_ASSERT(a_done_not_busy, clk, rst_n, (out_valid_r && out_done_r) |-> !out_bits_r[2])
  `SDSUM_ASSERT(a_start_from_idle, clk, rst_n,
    (in_acc && (act == ACT_START) && (phase_r == PH_IDLE)) |=> (phase_r == PH_START))

endmodule
`default_nettype wire
